// ===== rtl/core/srsg_pkg.sv =====
package srsg_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_CRUISE_PERIOD     = 2'd0;
    localparam logic [1:0] CFG_RAMP_START_PERIOD = 2'd1;
    localparam logic [1:0] CFG_MIN_RAMP_STEPS    = 2'd2;

    // Register reset values
    localparam logic [15:0] RST_CRUISE_PERIOD     = 16'd300;
    localparam logic [15:0] RST_RAMP_START_PERIOD = 16'd800;
    localparam logic [15:0] RST_MIN_RAMP_STEPS    = 16'd20;

    // Operation codes carried in tuser
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Field and bus widths
    localparam int unsigned REG_BITS    = 16;
    localparam int unsigned PERIOD_BITS = 16;
    localparam int unsigned IN_BITS     = 24;
    localparam int unsigned OUT_BITS    = 24;

    // The ramp length is the step count divided by this
    localparam int unsigned RAMP_DIVISOR = 3;

    // Reciprocal of the divisor: for any 16-bit count, count / 3 equals
    // (count * RAMP_RECIP) >> RAMP_RECIP_SHIFT exactly.
    localparam logic [15:0] RAMP_RECIP       = 16'hAAAB;
    localparam int unsigned RAMP_RECIP_SHIFT = 17;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPAN,
        ST_DIFF,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_RAMP,
        ST_FIN,
        ST_PUSH
    } t_state;

endpackage

// ===== rtl/core/stepper_ramp_step_generator.sv =====
// A tick that issues a step passes the span, difference, multiply and load states, the
// 16-iteration restoring divider that scales the ramp delay, then finish and push. A start
// command passes multiply, ramp and push, the shared multiplier forming count / 3 by a
// reciprocal. Every other item goes straight to push. The result register lets the next
// item enter while a result waits. Reset is synchronous and active low: it loads the
// register defaults (300, 800, 20), clears all move state and empties the result register.
module stepper_ramp_step_generator #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,  // [15:0] step_count, [16] direction, [23:17] zero
    input  logic        i_s_tuser,  // [0] operation
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,  // [0] step_fire, [1] direction_level, [2] moving_flag,
                                    // [3] move_done, [4] command_rejected,
                                    // [20:5] steps_issued, [23:21] zero
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import srsg_pkg::*;

    localparam int unsigned CB = COUNT_BITS;
    localparam int unsigned QW = (COUNT_BITS > PERIOD_BITS) ? COUNT_BITS : PERIOD_BITS;
    localparam int unsigned MW = PERIOD_BITS + COUNT_BITS;
    localparam int unsigned IW = $clog2(QW + 1);

    // Control and move state
    t_state            r_state, n_state;
    logic              r_moving, n_moving;
    logic              r_dir, n_dir;
    logic [CB-1:0]     r_target, n_target;
    logic [CB-1:0]     r_pos, n_pos;
    logic [CB-1:0]     r_ramp, n_ramp;
    logic [CB-1:0]     r_wait, n_wait;
    logic              r_ovalid, n_ovalid;
    logic              r_ramp_job, n_ramp_job;
    logic [IW-1:0]     r_iter, n_iter;
    logic [15:0]       r_cruise, r_rsp, r_minramp;

    // Working registers of the shared datapath
    logic [CB-1:0]     r_a, n_a;
    logic [CB-1:0]     r_b, n_b;
    logic [15:0]       r_spanmag, n_spanmag;
    logic              r_neg, n_neg;
    logic [MW-1:0]     r_prod, n_prod;
    logic [CB-1:0]     r_rem, n_rem;
    logic [QW-1:0]     r_quo, n_quo;
    logic [CB-1:0]     r_dvs, n_dvs;
    logic              r_fire, n_fire;
    logic              r_done, n_done;
    logic              r_rej, n_rej;
    logic [OUT_BITS-1:0] r_odata, n_odata;

    // Datapath intermediates
    logic [CB-1:0]     w_cnt;
    logic [CB-1:0]     w_wdec;
    logic [CB-1:0]     w_toend;
    logic [16:0]       w_span;
    logic [16:0]       w_negspan;
    logic [CB:0]       w_trial;
    logic [CB:0]       w_trial_sub;
    logic              w_ge;
    logic [QW-1:0]     w_cnt3;
    logic [QW-1:0]     w_minr;
    logic [QW-1:0]     w_rampq;
    logic [CB-1:0]     w_rampv;
    logic [17:0]       w_q;
    logic [17:0]       w_qs;
    logic [17:0]       w_d;

    assign w_cnt       = COUNT_BITS'(i_s_tdata[15:0]);
    assign w_wdec      = (r_wait != '0) ? (r_wait - CB'(1)) : r_wait;
    assign w_toend     = r_target - r_pos - CB'(1);
    assign w_span      = {1'b0, r_rsp} - {1'b0, r_cruise};
    assign w_negspan   = 17'd0 - w_span;

    // One restoring divider step
    assign w_trial     = {r_rem, r_quo[QW-1]};
    assign w_trial_sub = w_trial - {1'b0, r_dvs};
    assign w_ge        = (w_trial >= {1'b0, r_dvs});

    // Ramp length from the scaled count and the minimum ramp
    assign w_cnt3      = QW'(r_prod[MW-1:RAMP_RECIP_SHIFT]);
    assign w_minr      = QW'(r_minramp);
    assign w_rampq     = (w_cnt3 < w_minr) ? w_minr : w_cnt3;
    assign w_rampv     = COUNT_BITS'(w_rampq);

    // Delay from the signed quotient
    assign w_q         = {2'b00, r_quo[PERIOD_BITS-1:0]};
    assign w_qs        = r_neg ? (18'd0 - w_q) : w_q;
    assign w_d         = {2'b00, r_cruise} + w_qs;

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = r_odata;

    // Sequencer: next state and datapath updates
    always_comb begin
        n_state    = r_state;
        n_moving   = r_moving;
        n_dir      = r_dir;
        n_target   = r_target;
        n_pos      = r_pos;
        n_ramp     = r_ramp;
        n_wait     = r_wait;
        n_ovalid   = r_ovalid;
        n_ramp_job = r_ramp_job;
        n_iter     = r_iter;
        n_a        = r_a;
        n_b        = r_b;
        n_spanmag  = r_spanmag;
        n_neg      = r_neg;
        n_prod     = r_prod;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_dvs      = r_dvs;
        n_fire     = r_fire;
        n_done     = r_done;
        n_rej      = r_rej;
        n_odata    = r_odata;

        // The taken result leaves the output register
        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_fire  = 1'b0;
                    n_done  = 1'b0;
                    n_rej   = 1'b0;
                    n_state = ST_PUSH;
                    if (i_s_tuser == OP_START) begin
                        if (r_moving) begin
                            n_rej = 1'b1;
                        end else begin
                            // Latch the move and scale the count by the reciprocal of three
                            n_dir      = i_s_tdata[16];
                            n_target   = w_cnt;
                            n_pos      = '0;
                            n_wait     = '0;
                            n_moving   = 1'b1;
                            n_spanmag  = RAMP_RECIP;
                            n_a        = w_cnt;
                            n_ramp_job = 1'b1;
                            n_state    = ST_MUL;
                        end
                    end else if (r_moving) begin
                        n_wait = w_wdec;
                        if (w_wdec == '0) begin
                            if (r_pos >= r_target) begin
                                n_moving = 1'b0;
                                n_done   = 1'b1;
                            end else begin
                                n_state = ST_SPAN;
                            end
                        end
                    end
                end
            end

            ST_SPAN: begin
                // Distances to both ends of the move, clamped to the ramp
                n_a       = (r_pos < r_ramp) ? r_pos : r_ramp;
                n_b       = (w_toend < r_ramp) ? w_toend : r_ramp;
                n_neg     = w_span[16];
                n_spanmag = w_span[16] ? w_negspan[15:0] : w_span[15:0];
                n_state   = ST_DIFF;
            end

            ST_DIFF: begin
                n_a     = r_ramp - ((r_a < r_b) ? r_a : r_b);
                n_state = ST_MUL;
            end

            ST_MUL: begin
                n_prod  = MW'(r_spanmag) * MW'(r_a);
                n_state = r_ramp_job ? ST_RAMP : ST_LOAD;
            end

            ST_LOAD: begin
                // The quotient is below 2^16, so the top product bits start as remainder
                n_rem      = r_prod[MW-1:PERIOD_BITS];
                n_quo      = QW'(r_prod[PERIOD_BITS-1:0]) << (QW - PERIOD_BITS);
                n_dvs      = r_ramp;
                n_iter     = IW'(PERIOD_BITS);
                n_state    = ST_DIV;
            end

            ST_DIV: begin
                n_rem  = w_ge ? w_trial_sub[CB-1:0] : w_trial[CB-1:0];
                n_quo  = {r_quo[QW-2:0], w_ge};
                n_iter = r_iter - IW'(1);
                if (r_iter == IW'(1)) begin
                    n_state = ST_FIN;
                end
            end

            ST_RAMP: begin
                n_ramp     = (w_rampv == '0) ? CB'(1) : w_rampv;
                n_ramp_job = 1'b0;
                n_state    = ST_PUSH;
            end

            ST_FIN: begin
                // Load the delay to the next step and issue this one
                n_wait  = w_d[17] ? '0 : COUNT_BITS'(w_d[16:0]);
                n_pos   = r_pos + CB'(1);
                n_fire  = 1'b1;
                n_state = ST_PUSH;
            end

            ST_PUSH: begin
                if (!r_ovalid || i_m_tready) begin
                    n_odata  = {3'b000, 16'(r_pos), r_rej, r_done, r_moving, r_dir, r_fire};
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control, move state and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_moving   <= 1'b0;
            r_dir      <= 1'b0;
            r_target   <= '0;
            r_pos      <= '0;
            r_ramp     <= '0;
            r_wait     <= '0;
            r_ovalid   <= 1'b0;
            r_ramp_job <= 1'b0;
            r_iter     <= '0;
            r_cruise   <= RST_CRUISE_PERIOD;
            r_rsp      <= RST_RAMP_START_PERIOD;
            r_minramp  <= RST_MIN_RAMP_STEPS;
        end else begin
            r_state    <= n_state;
            r_moving   <= n_moving;
            r_dir      <= n_dir;
            r_target   <= n_target;
            r_pos      <= n_pos;
            r_ramp     <= n_ramp;
            r_wait     <= n_wait;
            r_ovalid   <= n_ovalid;
            r_ramp_job <= n_ramp_job;
            r_iter     <= n_iter;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CRUISE_PERIOD:     r_cruise  <= i_cfg_data;
                    CFG_RAMP_START_PERIOD: r_rsp     <= i_cfg_data;
                    CFG_MIN_RAMP_STEPS:    r_minramp <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_a       <= n_a;
        r_b       <= n_b;
        r_spanmag <= n_spanmag;
        r_neg     <= n_neg;
        r_prod    <= n_prod;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_dvs     <= n_dvs;
        r_fire    <= n_fire;
        r_done    <= n_done;
        r_rej     <= n_rej;
        r_odata   <= n_odata;
    end

endmodule

// ===== bench/tb_stepper_ramp_step_generator.sv =====
`timescale 1ns / 100ps

module tb_stepper_ramp_step_generator;
    import srsg_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES   = 200;

    // Item layouts, last field in the lowest bits.
    typedef struct packed {
        logic [6:0]  pad;
        logic        direction;
        logic [15:0] step_count;
    } move_cmd_t;

    typedef struct packed {
        logic [2:0]  pad;
        logic [15:0] steps_issued;
        logic        rejected;
        logic        done;
        logic        moving;
        logic        dir_level;
        logic        fire;
    } step_report_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;
    logic        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    // Shadow copy of the registers and of the move state.
    logic [15:0] cfg_cruise;
    logic [15:0] cfg_ramp_start;
    logic [15:0] cfg_min_ramp;
    logic        track_moving;
    logic        track_dir;
    logic [15:0] track_target;
    logic [15:0] track_pos;
    logic [15:0] track_ramp;
    logic [15:0] track_wait;

    step_report_t expected_reports[$];
    int unsigned  error_count;
    int unsigned  items_sent;
    int unsigned  cycle_count;
    bit           sender_steady;
    bit           sink_steady;
    bit           sink_hold_req;

    stepper_ramp_step_generator dut (.*);

    // Clock, 12 ns period.
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Run watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run timed out", $time);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Delay before the step after position pos: linear from the ramp period down to
    // the cruise period over the ramp at each end, quotient truncated toward zero.
    function automatic logic [15:0] step_delay(input logic [15:0] pos);
        longint from_start, to_end, active, span, num, quot, dly;
        from_start = longint'((pos < track_ramp) ? pos : track_ramp);
        to_end = longint'(track_target) - 1 - longint'(pos);
        if (to_end > longint'(track_ramp)) to_end = longint'(track_ramp);
        active = (from_start < to_end) ? from_start : to_end;
        span = longint'(cfg_ramp_start) - longint'(cfg_cruise);
        num = span * (longint'(track_ramp) - active);
        quot = num / longint'(track_ramp);
        dly = longint'(cfg_cruise) + quot;
        if (dly < 0) dly = 0;
        return dly[15:0];
    endfunction

    // Advances the shadow state by one item and returns the report it produces.
    function automatic step_report_t predict_report(input logic op, input logic [15:0] cnt,
                                                    input logic dir);
        step_report_t rpt;
        logic [15:0]  ramp;
        rpt = '0;
        if (op == OP_START) begin
            if (track_moving) begin
                rpt.rejected = 1'b1;
            end else begin
                ramp = 16'(cnt / RAMP_DIVISOR);
                if (ramp < cfg_min_ramp) ramp = cfg_min_ramp;
                if (ramp == 16'd0) ramp = 16'd1;
                track_dir    = dir;
                track_target = cnt;
                track_pos    = '0;
                track_ramp   = ramp;
                track_wait   = '0;
                track_moving = 1'b1;
            end
        end else if (track_moving) begin
            if (track_wait != 16'd0) track_wait = track_wait - 16'd1;
            if (track_wait == 16'd0) begin
                if (track_pos >= track_target) begin
                    track_moving = 1'b0;
                    rpt.done = 1'b1;
                end else begin
                    track_wait = step_delay(track_pos);
                    track_pos  = track_pos + 16'd1;
                    rpt.fire   = 1'b1;
                end
            end
        end
        rpt.dir_level    = track_dir;
        rpt.moving       = track_moving;
        rpt.steps_issued = track_pos;
        return rpt;
    endfunction

    function automatic void check_field(input string what, input int unsigned want_v,
                                        input int unsigned got_v);
        if (want_v != got_v) begin
            error_count++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want_v, got_v);
        end
    endfunction

    // Result checker: every accepted item is compared with the oldest expectation.
    always @(posedge i_clk) begin
        step_report_t got;
        step_report_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            if (expected_reports.size() == 0) begin
                error_count++;
                $display("%0t: unexpected item, expected none, got %h", $time, got);
            end else begin
                want = expected_reports.pop_front();
                check_field("step_fire", 32'(want.fire), 32'(got.fire));
                check_field("direction_level", 32'(want.dir_level), 32'(got.dir_level));
                check_field("moving_flag", 32'(want.moving), 32'(got.moving));
                check_field("move_done", 32'(want.done), 32'(got.done));
                check_field("command_rejected", 32'(want.rejected), 32'(got.rejected));
                check_field("steps_issued", 32'(want.steps_issued),
                            32'(got.steps_issued));
            end
        end
    end

    // Result sink: random stall per item, plus one long hold-off on request.
    initial begin : result_sink
        int unsigned gap;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_req) begin
                i_m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                sink_hold_req = 1'b0;
            end
            gap = sink_steady ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                i_m_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_tready = 1'b1;
            do @(posedge i_clk); while (!(o_m_tvalid && i_m_tready));
        end
    end

    // Offers one item after a random gap and records its expected report on acceptance.
    task automatic send_item(input logic op, input logic [15:0] cnt, input logic dir);
        int unsigned gap;
        move_cmd_t   cmd;
        @(negedge i_clk);
        gap = sender_steady ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd            = '0;
        cmd.step_count = cnt;
        cmd.direction  = dir;
        i_s_tdata      = cmd;
        i_s_tuser      = op;
        i_s_tvalid     = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        expected_reports.push_back(predict_report(op, cnt, dir));
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(OP_TICK, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
    endtask

    // Ticks until the current move has completed.
    task automatic run_until_idle();
        while (track_moving) send_tick();
    endtask

    // Stops offering items and waits until every report has arrived and the block settled.
    task automatic drain_results();
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_CRUISE_PERIOD:     cfg_cruise = value;
            CFG_RAMP_START_PERIOD: cfg_ramp_start = value;
            CFG_MIN_RAMP_STEPS:    cfg_min_ramp = value;
            default: ;
        endcase
    endtask

    // Mostly complete moves with random content, some idle ticks and rejected starts.
    task automatic send_random_item();
        int unsigned roll;
        logic [15:0] cnt;
        roll = $urandom_range(0, 99);
        if (!track_moving) begin
            if (roll < 90) begin
                cnt = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 12))
                                                   : 16'($urandom_range(13, 40));
                send_item(OP_START, cnt, 1'($urandom_range(0, 1)));
            end else begin
                send_tick();
            end
        end else if (roll < 4) begin
            send_item(OP_START, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        end else begin
            send_tick();
        end
    endtask

    // Short periods keep moves brief; some settings put the ramp period below cruise.
    task automatic pick_random_settings();
        logic [15:0] cruise;
        logic [15:0] ramp_start;
        logic [15:0] min_ramp;
        cruise = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
        if ($urandom_range(0, 99) < 15) begin
            ramp_start = 16'($urandom_range(0, cruise));
        end else begin
            ramp_start = 16'($urandom_range(cruise, 10));
        end
        min_ramp = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(7, 30))
                                               : 16'($urandom_range(0, 6));
        write_register(CFG_CRUISE_PERIOD, cruise);
        write_register(CFG_RAMP_START_PERIOD, ramp_start);
        write_register(CFG_MIN_RAMP_STEPS, min_ramp);
    endtask

    task automatic test_idle_tick();
        send_tick();
    endtask

    task automatic test_zero_count();
        drain_results();
        write_register(CFG_CRUISE_PERIOD, 16'd1);
        write_register(CFG_RAMP_START_PERIOD, 16'd3);
        send_item(OP_START, 16'd0, 1'b1);
        run_until_idle();
    endtask

    // Zero minimum ramp with a short count, zero delays, and a start while moving.
    task automatic test_zero_ramp_and_delay();
        drain_results();
        write_register(CFG_CRUISE_PERIOD, 16'd0);
        write_register(CFG_RAMP_START_PERIOD, 16'd0);
        write_register(CFG_MIN_RAMP_STEPS, 16'd0);
        send_item(OP_START, 16'd2, 1'b0);
        send_tick();
        send_item(OP_START, 16'hFFFF, 1'b1);
        run_until_idle();
    endtask

    // Ramp period below cruise: negative slope, quotient truncated toward zero.
    task automatic test_reversed_ramp();
        drain_results();
        write_register(CFG_CRUISE_PERIOD, 16'd4);
        write_register(CFG_RAMP_START_PERIOD, 16'd2);
        write_register(CFG_MIN_RAMP_STEPS, 16'd3);
        send_item(OP_START, 16'd4, 1'b1);
        run_until_idle();
    endtask

    task automatic test_wide_min_ramp();
        drain_results();
        write_register(CFG_CRUISE_PERIOD, 16'd1);
        write_register(CFG_RAMP_START_PERIOD, 16'd3);
        write_register(CFG_MIN_RAMP_STEPS, 16'hFFFF);
        send_item(OP_START, 16'd2, 1'b0);
        run_until_idle();
    endtask

    // The sink holds off for a long stretch while items keep coming back to back.
    task automatic test_backpressure();
        drain_results();
        pick_random_settings();
        sink_hold_req = 1'b1;
        sender_steady = 1'b1;
        repeat (24) send_random_item();
        sender_steady = 1'b0;
    endtask

    task automatic test_random_moves(input int unsigned n_items);
        int unsigned goal;
        int unsigned phase_len;
        goal = items_sent + n_items;
        while (items_sent < goal) begin
            drain_results();
            pick_random_settings();
            sender_steady = ($urandom_range(0, 4) == 0);
            sink_steady   = ($urandom_range(0, 4) == 0);
            phase_len     = $urandom_range(60, 120);
            repeat (phase_len) send_random_item();
        end
        sender_steady = 1'b0;
        sink_steady   = 1'b0;
    endtask

    // Full-scale count and register extremes; the move is left running at the end.
    task automatic test_long_move();
        drain_results();
        write_register(CFG_CRUISE_PERIOD, 16'd1);
        write_register(CFG_RAMP_START_PERIOD, 16'hFFFF);
        write_register(CFG_MIN_RAMP_STEPS, 16'hFFFF);
        send_item(OP_START, 16'hFFFF, 1'b1);
        repeat (6) send_tick();
        send_item(OP_START, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        drain_results();
        write_register(CFG_CRUISE_PERIOD, 16'hFFFF);
        repeat (3) send_tick();
    endtask

    // Main sequence.
    initial begin
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = OP_TICK;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_CRUISE_PERIOD;
        i_cfg_data     = '0;
        error_count    = 0;
        items_sent     = 0;
        cycle_count    = 0;
        sender_steady  = 1'b0;
        sink_steady    = 1'b0;
        sink_hold_req  = 1'b0;
        cfg_cruise     = RST_CRUISE_PERIOD;
        cfg_ramp_start = RST_RAMP_START_PERIOD;
        cfg_min_ramp   = RST_MIN_RAMP_STEPS;
        track_moving   = 1'b0;
        track_dir      = 1'b0;
        track_target   = '0;
        track_pos      = '0;
        track_ramp     = '0;
        track_wait     = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_idle_tick();
        test_zero_count();
        test_zero_ramp_and_delay();
        test_reversed_ramp();
        test_wide_min_ramp();
        test_backpressure();
        test_random_moves(1000);
        test_long_move();

        drain_results();
        if (error_count == 0 && expected_reports.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
